/* sv/periodic_min_image_distance_2d_defines.svh */
// Assertion macros for the minimum-image distance block.
`ifndef PERIODIC_MIN_IMAGE_DISTANCE_2D_DEFINES_SVH
`define PERIODIC_MIN_IMAGE_DISTANCE_2D_DEFINES_SVH

`ifndef SYNTHESIS

`define PMID_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define PMID_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PMID_ASSERT(lbl, clk, rst, prop, msg)

`define PMID_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* sv/pmid_pkg.sv */
// Shared types and constants for the minimum-image distance block.
package pmid_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 31;
  localparam int DIST_W      = 32;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int RAD_W       = 2 * DIST_W;
  localparam int REM_W       = DIST_W + 2;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COORD_W-1:0] BOX_RESET = COORD_W'(64'd1 << FRAC_BITS);
  localparam logic [DIST_W-1:0]  DIST_MAX  = 32'd3037000499;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DIST_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } pmid_sqrt_t;

endpackage

/* sv/pmid_axis.sv */
// One axis: absolute difference, then fold to the nearest periodic image.
module pmid_axis (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pmid_pkg::COORD_W-1:0]  p,
  input  logic [pmid_pkg::COORD_W-1:0]  q,
  input  logic [pmid_pkg::COORD_W-1:0]  len,
  output logic [pmid_pkg::COORD_W-1:0]  d
);
  import pmid_pkg::*;

  logic [COORD_W-1:0] diff;
  logic [COORD_W-1:0] diff_next;
  logic [COORD_W-1:0] d_next;

  always_comb begin
    diff_next = (p >= q) ? (p - q) : (q - p);
  end

  always_comb begin
    if ({diff, 1'b0} > {1'b0, len}) begin
      d_next = (len >= diff) ? (len - diff) : (diff - len);
    end else begin
      d_next = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_next;
      d    <= d_next;
    end
  end

endmodule

/* sv/pmid_sqrt_cell.sv */
// One root bit of the integer square root chain.
module pmid_sqrt_cell (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    v_in,
  input  pmid_pkg::pmid_sqrt_t    d_in,
  output logic                    v_out,
  output pmid_pkg::pmid_sqrt_t    d_out
);
  import pmid_pkg::*;

  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic             take;
  pmid_sqrt_t       d_next;

  always_comb begin
    rem_t       = {d_in.rem, d_in.rad[RAD_W-1 -: 2]};
    trial       = {2'b00, d_in.root, 2'b01};
    take        = (rem_t >= trial);
    d_next.rad  = {d_in.rad[RAD_W-3:0], 2'b00};
    if (take) begin
      d_next.rem  = REM_W'(rem_t - trial);
      d_next.root = {d_in.root[DIST_W-2:0], 1'b1};
    end else begin
      d_next.rem  = rem_t[REM_W-1:0];
      d_next.root = {d_in.root[DIST_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

/* sv/periodic_min_image_distance_2d.sv */
// Top level: minimum-image distance of two points in a periodic 2-D box.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata: ax, ay, bx, by (31 bits each)
//   m_*      out  m_tvalid/m_tready    tdata: dist_res (32 bits)
//   cfg_*    in   cfg_valid/cfg_ready  data: box_length (31 bits)
//
// One word per cycle while the skid buffer is empty; stages: difference,
// fold, square, sum, one cell per root bit (32), output register.
// Reset clears all valid bits and sets box_length to 1.0.
// A one-entry skid buffer takes the word in flight when m_tready drops;
// s_tready falls only while that buffer is full.
`include "periodic_min_image_distance_2d_defines.svh"

module periodic_min_image_distance_2d (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // ax [30:0], ay [61:31], bx [92:62], by [123:93], zero [127:124]
  input  logic [pmid_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // dist_res [31:0]
  output logic [pmid_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pmid_pkg::COORD_W-1:0]       cfg_data
);
  import pmid_pkg::*;

  logic [COORD_W-1:0] box_length;
  logic               en;
  logic [3:0]         v_pre;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [SQ_W-1:0]    sqx;
  logic [SQ_W-1:0]    sqy;
  logic [SUM_W-1:0]   sum;
  logic               v_cell [DIST_W+1];
  pmid_sqrt_t         d_cell [DIST_W+1];
  logic               pv;
  logic               skid_valid;
  logic [DIST_W-1:0]  skid_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length <= BOX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      box_length <= cfg_data;
    end
  end

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_pre <= '0;
    end else if (en) begin
      v_pre <= {v_pre[2:0], s_tvalid};
    end
  end

  pmid_axis u_axis_x (
    .clk (clk),
    .en  (en),
    .p   (s_tdata[COORD_W-1:0]),
    .q   (s_tdata[3*COORD_W-1:2*COORD_W]),
    .len (box_length),
    .d   (dx)
  );

  pmid_axis u_axis_y (
    .clk (clk),
    .en  (en),
    .p   (s_tdata[2*COORD_W-1:COORD_W]),
    .q   (s_tdata[4*COORD_W-1:3*COORD_W]),
    .len (box_length),
    .d   (dy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sqx <= SQ_W'(dx * dx);
      sqy <= SQ_W'(dy * dy);
      sum <= SUM_W'(sqx) + SUM_W'(sqy);
    end
  end

  assign v_cell[0]      = v_pre[3];
  assign d_cell[0].rem  = '0;
  assign d_cell[0].root = '0;
  assign d_cell[0].rad  = RAD_W'(sum);

  for (genvar i = 0; i < DIST_W; i++) begin : g_cell
    pmid_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .v_in  (v_cell[i]),
      .d_in  (d_cell[i]),
      .v_out (v_cell[i+1]),
      .d_out (d_cell[i+1])
    );
  end

  assign pv = v_cell[DIST_W] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= pv;
      end
    end else if (pv) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
      end else if (pv) begin
        m_tdata <= d_cell[DIST_W].root;
      end
    end else if (pv) begin
      skid_data <= d_cell[DIST_W].root;
    end
  end

  `PMID_ASSERT(a_skid_needs_out, clk, rst, skid_valid |-> m_tvalid, "skid word without output word")
  `PMID_ASSERT(a_skid_on_stall, clk, rst, $rose(skid_valid) |-> $past(m_tvalid && !m_tready), "skid filled without stall")
  `PMID_ASSERT(a_chain_to_out, clk, rst, (v_cell[DIST_W] && !skid_valid) |=> m_tvalid, "finished word lost")
  `PMID_ASSERT(a_dist_range, clk, rst, m_tvalid |-> (m_tdata <= DIST_MAX), "distance out of range")

endmodule
